>>> rtl/ppi_pkg.sv
// ============================================================================
// ppi_pkg: shared types, constants and functions of the pose integrator
// Holds the microcode format and program, CORDIC tables and the fixed-point
// helpers used by the sequencer and the datapath.
// ============================================================================
package ppi_pkg;

    // Widths of state and arithmetic
    localparam int ANGLE_BITS    = 16;
    localparam int POS_BITS      = 32;
    localparam int CORDIC_STAGES = 16;
    localparam int ITER_W        = $clog2(CORDIC_STAGES);
    localparam int ACC_W         = 64;
    localparam int RX_W          = ACC_W - 30;
    localparam int SUM_W         = ((POS_BITS > RX_W) ? POS_BITS : RX_W) + 1;

    localparam logic signed [31:0]      CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [ACC_W-1:0] ROUND_Q30   = 64'sd536870912;
    localparam logic signed [33:0]      FLIP_LIMIT  = -34'sd4294967296;
    localparam logic signed [16:0]      Q14_MAX     = 17'sd16384;
    localparam logic signed [16:0]      Q14_MIN     = -17'sd16384;

    localparam logic signed [SUM_W-1:0] POS_MAX =
        SUM_W'((65'sd1 <<< (POS_BITS - 1)) - 65'sd1);
    localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

    // Rotation angles in 32-bit binary units
    localparam logic signed [31:0] ATAN_TURNS [CORDIC_STAGES] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
    };

    // Program addresses
    typedef enum logic [3:0] {
        PC_IDLE,
        PC_M_SC,
        PC_M_CC,
        PC_M_SS,
        PC_SUB,
        PC_CH,
        PC_RX0,
        PC_RX1,
        PC_RY0,
        PC_RY1,
        PC_UPD,
        PC_CORDIC,
        PC_QUAT
    } t_pc;

    typedef enum logic [1:0] {MA_C, MA_S, MA_DX, MA_DY} t_mul_a;
    typedef enum logic [1:0] {MB_C, MB_S, MB_SH, MB_CH} t_mul_b;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_RND_ADD, ACC_RND_SUB
    } t_acc_op;

    typedef enum logic [2:0] {
        WR_NONE, WR_INPUT, WR_SH, WR_CH, WR_PX, WR_UPD, WR_CORDIC, WR_QUAT
    } t_wr_op;

    typedef enum logic [1:0] {
        BR_NEXT, BR_WAIT_IN, BR_LOOP, BR_WAIT_OUT
    } t_br_op;

    typedef struct packed {
        t_mul_a  mul_a;
        t_mul_b  mul_b;
        t_acc_op acc_op;
        t_wr_op  wr_op;
        t_br_op  br_op;
        t_pc     target;
    } t_ucode;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic iter_last;
    } t_cond;

    // Control store: one word per step
    function automatic t_ucode ucode_rom(input t_pc pc);
        t_ucode w;
        w = '{mul_a: MA_C, mul_b: MB_C, acc_op: ACC_HOLD, wr_op: WR_NONE,
              br_op: BR_NEXT, target: PC_IDLE};
        case (pc)
            PC_IDLE: begin
                w.wr_op  = WR_INPUT;
                w.br_op  = BR_WAIT_IN;
                w.target = PC_M_SC;
            end
            PC_M_SC: begin
                w.mul_a = MA_S;  w.mul_b = MB_C;
            end
            PC_M_CC: begin
                w.mul_a = MA_C;  w.mul_b = MB_C;  w.acc_op = ACC_LOAD;
            end
            PC_M_SS: begin
                w.mul_a = MA_S;  w.mul_b = MB_S;  w.acc_op = ACC_LOAD;
                w.wr_op = WR_SH;
            end
            PC_SUB: begin
                w.acc_op = ACC_SUB;
            end
            PC_CH: begin
                w.mul_a = MA_DY; w.mul_b = MB_SH; w.wr_op = WR_CH;
            end
            PC_RX0: begin
                w.mul_a = MA_DX; w.mul_b = MB_CH; w.acc_op = ACC_RND_SUB;
            end
            PC_RX1: begin
                w.mul_a = MA_DX; w.mul_b = MB_SH; w.acc_op = ACC_ADD;
            end
            PC_RY0: begin
                w.mul_a = MA_DY; w.mul_b = MB_CH; w.acc_op = ACC_RND_ADD;
                w.wr_op = WR_PX;
            end
            PC_RY1: begin
                w.acc_op = ACC_ADD;
            end
            PC_UPD: begin
                w.wr_op = WR_UPD;
            end
            PC_CORDIC: begin
                w.wr_op  = WR_CORDIC;
                w.br_op  = BR_LOOP;
                w.target = PC_QUAT;
            end
            PC_QUAT: begin
                w.wr_op  = WR_QUAT;
                w.br_op  = BR_WAIT_OUT;
                w.target = PC_IDLE;
            end
            default: begin
                w.br_op  = BR_WAIT_IN;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    // CORDIC result for a zero angle: the cached half-angle pair after reset
    function automatic logic signed [31:0] cordic_zero(input logic want_sin);
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        x = CORDIC_GAIN;
        y = '0;
        z = '0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = y >>> i;
            ys = x >>> i;
            if (!z[31]) begin
                x = x - xs;  y = y + ys;  z = z - ATAN_TURNS[i];
            end else begin
                x = x + xs;  y = y - ys;  z = z + ATAN_TURNS[i];
            end
        end
        return want_sin ? y : x;
    endfunction

    localparam logic signed [31:0] COS_ZERO = cordic_zero(1'b0);
    localparam logic signed [31:0] SIN_ZERO = cordic_zero(1'b1);

    // Heading as a signed 32-bit binary angle
    function automatic logic signed [31:0] wide_angle(input logic [ANGLE_BITS-1:0] h);
        return {h, {(32 - ANGLE_BITS){1'b0}}};
    endfunction

    // Saturating add of a rotated offset onto a coordinate
    function automatic logic signed [POS_BITS-1:0] sat_pos_add(
        input logic signed [POS_BITS-1:0] p,
        input logic signed [RX_W-1:0]     r
    );
        logic signed [SUM_W-1:0] sum;
        sum = SUM_W'(p) + SUM_W'(r);
        if (sum > POS_MAX) begin
            return POS_MAX[POS_BITS-1:0];
        end else if (sum < POS_MIN) begin
            return POS_MIN[POS_BITS-1:0];
        end
        return sum[POS_BITS-1:0];
    endfunction

    // Coordinate to the 32-bit output field
    function automatic logic [31:0] pos_to_out(input logic signed [POS_BITS-1:0] p);
        logic signed [63:0] t;
        t = 64'(p);
        return t[31:0];
    endfunction

    // Q2.30 to Q1.14, rounded and clamped
    function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [16:0] r;
        t = 33'(v) + 33'sd32768;
        r = 17'(t >>> 16);
        if (r > Q14_MAX) begin
            r = Q14_MAX;
        end else if (r < Q14_MIN) begin
            r = Q14_MIN;
        end
        return r[15:0];
    endfunction

endpackage

>>> rtl/ppi_seq.sv
// ============================================================================
// ppi_seq: microcode sequencer of the pose integrator
// Keeps the program counter, reads the control store and resolves the
// conditional jumps on input arrival, loop end and output space.
// ============================================================================
module ppi_seq import ppi_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cond  i_cond,
    output t_ucode o_ucode
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_ucode w_word;

    // Fetch the control word of the current step
    always_comb begin
        w_word  = ucode_rom(r_pc);
        o_ucode = w_word;
    end

    // Pick the next step
    always_comb begin
        n_pc = r_pc;
        case (w_word.br_op)
            BR_NEXT:     n_pc = t_pc'(r_pc + 4'd1);
            BR_WAIT_IN:  if (i_cond.in_valid) n_pc = w_word.target;
            BR_LOOP:     if (i_cond.iter_last) n_pc = w_word.target;
            BR_WAIT_OUT: if (i_cond.out_free) n_pc = w_word.target;
            default:     n_pc = PC_IDLE;
        endcase
    end

    // Advance the program counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

`ifndef SYNTHESIS
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_IDLE && i_cond.in_valid) |=> (r_pc == PC_M_SC))
        else $error("sequencer did not start on an arriving item");

    a_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_CORDIC && !i_cond.iter_last) |=> (r_pc == PC_CORDIC))
        else $error("rotation loop left early");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_QUAT && !i_cond.out_free) |=> (r_pc == PC_QUAT))
        else $error("result step left while output register full");
`endif

endmodule

>>> rtl/planar_pose_integrator.sv
// ============================================================================
// planar_pose_integrator: planar odometry pose composition
// Integrates body-frame motions into a saturating position and a wrapping
// heading, and reports each new pose with its z-rotation quaternion.
// ============================================================================
// Usage:
//   Slave stream carries one motion per item (dx, dy, turn). Master stream
//   carries one pose per item (index, x, y, quaternion z and w).
//   A microcoded sequencer drives one shared 32x32 multiplier, an
//   accumulator and an iterative CORDIC unit.
//   Each item passes through the accept step, nine multiply/accumulate
//   steps on the single multiplier, one update step, the sixteen-iteration
//   CORDIC loop and the result step; the next item is accepted only after
//   the result step of the one before.
//   The cosine/sine of the current half heading is kept from the previous
//   item, so one CORDIC run per item suffices.
//   Reset (synchronous, active low) returns to the origin, zero heading and
//   zero count; the cached half-angle pair is reloaded with its zero value.
//   When the receiver stalls, the finished pose waits in the output
//   register; the next item is still accepted and processed, and the block
//   holds at its final step until the output register is free.
// ============================================================================
module planar_pose_integrator import ppi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // delta_x[23:0], delta_y[47:24], turn_angle[63:48]
    // master stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [111:0] o_m_axis_tdata    // pose_index[15:0], pos_x[47:16], pos_y[79:48],
                                           // quat_z[95:80], quat_w[111:96]
);

    t_ucode w_ucode;
    t_cond  w_cond;
    logic   w_s_accept;
    logic   w_out_free;

    // Architectural state
    logic        [ANGLE_BITS-1:0] r_heading, n_heading;
    logic signed [POS_BITS-1:0]   r_px, n_px;
    logic signed [POS_BITS-1:0]   r_py, n_py;
    logic        [15:0]           r_count, n_count;
    logic signed [31:0]           r_c, n_c;
    logic signed [31:0]           r_s, n_s;
    logic                         r_out_valid, n_out_valid;

    // Datapath registers
    logic signed [23:0]     r_dx, n_dx;
    logic signed [23:0]     r_dy, n_dy;
    logic        [15:0]     r_turn, n_turn;
    logic signed [31:0]     r_z, n_z;
    logic        [ITER_W-1:0] r_iter, n_iter;
    logic signed [31:0]     r_sh, n_sh;
    logic signed [31:0]     r_ch, n_ch;
    logic signed [ACC_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic        [15:0]     r_out_index, n_out_index;
    logic        [31:0]     r_out_px, n_out_px;
    logic        [31:0]     r_out_py, n_out_py;
    logic signed [15:0]     r_out_qz, n_out_qz;
    logic signed [15:0]     r_out_qw, n_out_qw;

    // Combinational helpers
    logic signed [31:0]           w_mul_a;
    logic signed [31:0]           w_mul_b;
    logic signed [31:0]           w_head_sum;
    logic        [ANGLE_BITS-1:0] w_head_new;
    logic signed [31:0]           w_z_init;
    logic signed [31:0]           w_xs;
    logic signed [31:0]           w_ys;
    logic signed [31:0]           w_atan;
    logic signed [31:0]           w_angle;
    logic signed [33:0]           w_angle3;
    logic                         w_flip;
    logic signed [15:0]           w_qz;
    logic signed [15:0]           w_qw;

    ppi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_ucode (w_ucode)
    );

    // Handshake and sequencer conditions
    assign o_s_axis_tready = (w_ucode.wr_op == WR_INPUT);
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_cond          = '{in_valid:  i_s_axis_tvalid,
                               out_free:  w_out_free,
                               iter_last: (r_iter == ITER_W'(CORDIC_STAGES - 1))};

    // Multiplier operand selection
    always_comb begin
        case (w_ucode.mul_a)
            MA_C:    w_mul_a = r_c;
            MA_S:    w_mul_a = r_s;
            MA_DX:   w_mul_a = 32'(r_dx);
            MA_DY:   w_mul_a = 32'(r_dy);
            default: w_mul_a = r_c;
        endcase
        case (w_ucode.mul_b)
            MB_C:    w_mul_b = r_c;
            MB_S:    w_mul_b = r_s;
            MB_SH:   w_mul_b = r_sh;
            MB_CH:   w_mul_b = r_ch;
            default: w_mul_b = r_c;
        endcase
    end

    // Heading advance and CORDIC start angle
    assign w_head_sum = wide_angle(r_heading) + {r_turn, 16'h0000};
    assign w_head_new = w_head_sum[31 -: ANGLE_BITS];
    assign w_z_init   = wide_angle(w_head_new) >>> 1;

    // One CORDIC rotation
    assign w_xs   = r_s >>> r_iter;
    assign w_ys   = r_c >>> r_iter;
    assign w_atan = ATAN_TURNS[r_iter];

    // Quaternion of the new heading, sign flipped below -2pi/3
    assign w_angle  = wide_angle(r_heading);
    assign w_angle3 = 34'(w_angle) + (34'(w_angle) <<< 1);
    assign w_flip   = (w_angle3 < FLIP_LIMIT);
    assign w_qz     = w_flip ? -to_q14(r_s) : to_q14(r_s);
    assign w_qw     = w_flip ? -to_q14(r_c) : to_q14(r_c);

    // Datapath next values
    always_comb begin
        n_heading   = r_heading;
        n_px        = r_px;
        n_py        = r_py;
        n_count     = r_count;
        n_c         = r_c;
        n_s         = r_s;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_turn      = r_turn;
        n_z         = r_z;
        n_iter      = r_iter;
        n_sh        = r_sh;
        n_ch        = r_ch;
        n_out_index = r_out_index;
        n_out_px    = r_out_px;
        n_out_py    = r_out_py;
        n_out_qz    = r_out_qz;
        n_out_qw    = r_out_qw;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_prod      = w_mul_a * w_mul_b;

        // accumulator
        case (w_ucode.acc_op)
            ACC_LOAD:    n_acc = r_prod;
            ACC_ADD:     n_acc = r_acc + r_prod;
            ACC_SUB:     n_acc = r_acc - r_prod;
            ACC_RND_ADD: n_acc = ROUND_Q30 + r_prod;
            ACC_RND_SUB: n_acc = ROUND_Q30 - r_prod;
            default:     n_acc = r_acc;
        endcase

        // register writes
        case (w_ucode.wr_op)
            WR_INPUT: begin
                if (w_s_accept) begin
                    n_dx   = i_s_axis_tdata[23:0];
                    n_dy   = i_s_axis_tdata[47:24];
                    n_turn = i_s_axis_tdata[63:48];
                end
            end
            WR_SH: n_sh = r_acc[60:29];
            WR_CH: n_ch = r_acc[61:30];
            WR_PX: n_px = sat_pos_add(r_px, r_acc[ACC_W-1:30]);
            WR_UPD: begin
                n_py      = sat_pos_add(r_py, r_acc[ACC_W-1:30]);
                n_heading = w_head_new;
                n_count   = (r_count != 16'hFFFF) ? r_count + 16'd1 : r_count;
                n_c       = CORDIC_GAIN;
                n_s       = '0;
                n_z       = w_z_init;
                n_iter    = '0;
            end
            WR_CORDIC: begin
                if (!r_z[31]) begin
                    n_c = r_c - w_xs;  n_s = r_s + w_ys;  n_z = r_z - w_atan;
                end else begin
                    n_c = r_c + w_xs;  n_s = r_s - w_ys;  n_z = r_z + w_atan;
                end
                n_iter = ITER_W'(r_iter + 1'b1);
            end
            WR_QUAT: begin
                if (w_out_free) begin
                    n_out_index = r_count;
                    n_out_px    = pos_to_out(r_px);
                    n_out_py    = pos_to_out(r_py);
                    n_out_qz    = w_qz;
                    n_out_qw    = w_qw;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold pose state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading   <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_count     <= '0;
            r_c         <= COS_ZERO;
            r_s         <= SIN_ZERO;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_heading   <= n_heading;
            r_px        <= n_px;
            r_py        <= n_py;
            r_count     <= n_count;
            r_c         <= n_c;
            r_s         <= n_s;
            r_out_valid <= n_out_valid;
            r_iter      <= n_iter;
        end
    end

    // Advance payload registers
    always_ff @(posedge i_clk) begin
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_turn      <= n_turn;
        r_z         <= n_z;
        r_sh        <= n_sh;
        r_ch        <= n_ch;
        r_prod      <= n_prod;
        r_acc       <= n_acc;
        r_out_index <= n_out_index;
        r_out_px    <= n_out_px;
        r_out_py    <= n_out_py;
        r_out_qz    <= n_out_qz;
        r_out_qw    <= n_out_qw;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_qw, r_out_qz, r_out_py, r_out_px, r_out_index};

`ifndef SYNTHESIS
    a_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_index != 16'd0))
        else $error("pose index zero on a valid result");

    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_qz <= 16'sd16384 && r_out_qz >= -16'sd16384 &&
                         r_out_qw <= 16'sd16384 && r_out_qw >= -16'sd16384))
        else $error("quaternion component out of range");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> !o_s_axis_tready)
        else $error("second item accepted while one is at work");
`endif

endmodule

>>> dv/ppi_pose_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// ppi_pose_checker: pose scoreboard for the planar pose integrator
// Watches both streams. It works out each pose from the accepted motion items
// with its own fixed-point pose integrator, and compares every returned pose,
// field by field, with the oldest pose still waiting.
// ============================================================================
module ppi_pose_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // delta_x[23:0], delta_y[47:24], turn_angle[63:48]
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [111:0] i_m_axis_tdata,   // pose_index[15:0], pos_x[47:16], pos_y[79:48],
                                           // quat_z[95:80], quat_w[111:96]
    output int           o_pending,
    output int           o_checked,
    output int           o_errors
);

    localparam longint HALF_GAIN  = 64'sd652032874;
    localparam longint ROUND_HALF = 64'sd536870912;
    localparam longint FULL_TURN  = 64'sd4294967296;
    localparam longint POS_HI     = 64'sd2147483647;
    localparam longint POS_LO     = -64'sd2147483648;

    typedef struct {
        logic [15:0]        index;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } t_pose;

    t_pose              expected_poses[$];
    logic [15:0]        heading;
    logic signed [31:0] track_x;
    logic signed [31:0] track_y;
    logic [15:0]        step_total;
    int                 error_count;
    int                 checked_count;

    // Rotation angle of each CORDIC stage, 2^32 per turn
    function automatic longint arc_step(input int stage);
        case (stage)
            0:       return 536870912;
            1:       return 316933406;
            2:       return 167458907;
            3:       return 85004756;
            4:       return 42667331;
            5:       return 21354465;
            6:       return 10679838;
            7:       return 5340245;
            8:       return 2670163;
            9:       return 1335087;
            10:      return 667544;
            11:      return 333772;
            12:      return 166886;
            13:      return 83443;
            14:      return 41722;
            default: return 20861;
        endcase
    endfunction

    // Cosine and sine in Q2.30 of a 32-bit binary angle
    function automatic void cordic_rotate(input longint angle, output longint cos_v,
                                          output longint sin_v);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = HALF_GAIN;
        y = 0;
        z = angle;
        for (int i = 0; i < 16; i++) begin
            xs = y >>> i;
            ys = x >>> i;
            if (z >= 0) begin
                x = x - xs;
                y = y + ys;
                z = z - arc_step(i);
            end else begin
                x = x + xs;
                y = y - ys;
                z = z + arc_step(i);
            end
        end
        cos_v = x;
        sin_v = y;
    endfunction

    // Heading widened to a signed 32-bit binary angle
    function automatic longint heading_angle(input logic [15:0] h);
        return longint'($signed({h, 16'h0000}));
    endfunction

    // Q2.30 to Q1.14, rounded and clamped
    function automatic logic signed [15:0] to_quat_part(input longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 64'sd16384) begin
            r = 64'sd16384;
        end else if (r < -64'sd16384) begin
            r = -64'sd16384;
        end
        return r[15:0];
    endfunction

    function automatic logic signed [31:0] clamp_pos(input longint v);
        if (v > POS_HI) begin
            return POS_HI[31:0];
        end else if (v < POS_LO) begin
            return POS_LO[31:0];
        end
        return v[31:0];
    endfunction

    // Integrate one motion item and work out the pose it produces
    task automatic integrate_motion(input logic [63:0] motion, output t_pose pose);
        longint dx;
        longint dy;
        longint a;
        longint c;
        longint s;
        longint sin_h;
        longint cos_h;
        dx = longint'($signed(motion[23:0]));
        dy = longint'($signed(motion[47:24]));
        // rotate by the heading held before this item
        a = heading_angle(heading);
        cordic_rotate(a >>> 1, c, s);
        sin_h = (s * c) >>> 29;
        cos_h = (c * c - s * s) >>> 30;
        track_x = clamp_pos(longint'(track_x) + ((dx * cos_h - dy * sin_h + ROUND_HALF) >>> 30));
        track_y = clamp_pos(longint'(track_y) + ((dx * sin_h + dy * cos_h + ROUND_HALF) >>> 30));
        heading = heading + motion[63:48];
        if (step_total != 16'hFFFF) begin
            step_total = step_total + 16'd1;
        end
        // quaternion of the new heading, sign flipped below -2pi/3
        a = heading_angle(heading);
        cordic_rotate(a >>> 1, c, s);
        pose.index = step_total;
        pose.x     = track_x;
        pose.y     = track_y;
        pose.qz    = to_quat_part(s);
        pose.qw    = to_quat_part(c);
        if (3 * a < -FULL_TURN) begin
            pose.qz = -pose.qz;
            pose.qw = -pose.qw;
        end
    endtask

    task automatic report_failure(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input int pose_no, input string name, input longint got,
                               input longint want);
        if (got != want) begin
            report_failure($sformatf("pose %0d %s is %0d, expected %0d",
                                     pose_no, name, got, want));
        end
    endtask

    // Compare one returned pose with the oldest one waiting
    task automatic compare_pose(input logic [111:0] beat);
        t_pose want;
        if (expected_poses.size() == 0) begin
            report_failure($sformatf("pose with index %0d arrived with none waiting",
                                     beat[15:0]));
            return;
        end
        want = expected_poses.pop_front();
        checked_count++;
        check_field(checked_count, "pose_index", longint'(beat[15:0]), longint'(want.index));
        check_field(checked_count, "pos_x", longint'($signed(beat[47:16])), longint'(want.x));
        check_field(checked_count, "pos_y", longint'($signed(beat[79:48])), longint'(want.y));
        check_field(checked_count, "quat_z", longint'($signed(beat[95:80])), longint'(want.qz));
        check_field(checked_count, "quat_w", longint'($signed(beat[111:96])),
                    longint'(want.qw));
    endtask

    // Track accepted items on both streams
    always @(posedge i_clk) begin
        t_pose next_pose;
        if (!i_rst_n) begin
            expected_poses.delete();
            heading       = '0;
            track_x       = '0;
            track_y       = '0;
            step_total    = '0;
            error_count   = 0;
            checked_count = 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                integrate_motion(i_s_axis_tdata, next_pose);
                expected_poses.push_back(next_pose);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                compare_pose(i_m_axis_tdata);
            end
        end
        o_pending <= expected_poses.size();
        o_checked <= checked_count;
        o_errors  <= error_count;
    end

endmodule

>>> dv/tb_planar_pose_integrator.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_planar_pose_integrator: stream testbench of the planar pose integrator
// Drives motion items with random gaps and stalls the pose stream at random.
// A directed set covers field extremes and heading corners, then random items
// run with a long straight drive into position saturation. The pose checker
// beside the block predicts and compares every pose.
// ============================================================================
module tb_planar_pose_integrator;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          IDLE_PCT      = 16;
    localparam logic [23:0] D_MAX         = 24'h7FFFFF;
    localparam logic [23:0] D_MIN         = 24'h800000;
    localparam logic [23:0] D_NEG_ONE     = 24'hFFFFFF;
    localparam logic [15:0] TURN_NONE     = 16'h0000;
    localparam logic [15:0] TURN_QUARTER  = 16'h4000;
    localparam logic [15:0] TURN_HALF     = 16'h8000;
    localparam logic [15:0] TURN_MAX      = 16'h7FFF;
    localparam logic [15:0] TURN_NEG_ONE  = 16'hFFFF;
    localparam logic [15:0] TURN_THIRD    = 16'h5555;   // 21845, just under 2pi/3
    localparam logic [15:0] TURN_NEG_TRD  = 16'hAAAB;   // -21845

    logic         i_clk           = 1'b0;
    logic         i_rst_n         = 1'b0;
    logic         s_axis_tvalid   = 1'b0;
    logic [63:0]  s_axis_tdata    = '0;
    logic         s_axis_tready;
    logic         m_axis_tvalid;
    logic         m_axis_tready   = 1'b0;
    logic [111:0] m_axis_tdata;

    int           idle_pct        = IDLE_PCT;
    int           cycle_count     = 0;
    int           sent_count      = 0;
    logic [15:0]  sent_heading    = '0;
    int           pending;
    int           checked;
    int           errors;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    planar_pose_integrator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata)
    );

    ppi_pose_checker pose_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_errors        (errors)
    );

    // Stall the pose stream at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d poses still waiting", cycle_count, pending);
            $display("FAIL planar_pose_integrator");
            $finish;
        end
    end

    // Offer one motion item, with random idle cycles ahead of it
    task automatic send_motion(input logic [23:0] dx, input logic [23:0] dy,
                               input logic [15:0] turn);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {turn, dy, dx};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        sent_heading = sent_heading + turn;
        sent_count++;
    endtask

    // Hold off the sender until every pose is back
    task automatic drain_poses();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [23:0] corner_offset();
        case ($urandom_range(0, 4))
            0:       return D_MAX;
            1:       return D_MIN;
            2:       return D_NEG_ONE;
            3:       return 24'h000001;
            default: return '0;
        endcase
    endfunction

    // One random motion: full range, small moves, corners or corner turns
    task automatic send_random_motion();
        logic [23:0] dx;
        logic [23:0] dy;
        logic [15:0] turn;
        int          pick;
        pick = $urandom_range(0, 9);
        dx   = 24'($urandom);
        dy   = 24'($urandom);
        turn = 16'($urandom);
        if (pick == 5 || pick == 6) begin
            dx   = 24'($urandom_range(0, 8191)) - 24'd4096;
            dy   = 24'($urandom_range(0, 8191)) - 24'd4096;
            turn = 16'($urandom_range(0, 1023)) - 16'd512;
        end else if (pick == 7) begin
            dx = corner_offset();
            dy = corner_offset();
        end else if (pick >= 8) begin
            case ($urandom_range(0, 7))
                0:       turn = TURN_NONE;
                1:       turn = TURN_HALF;
                2:       turn = TURN_QUARTER;
                3:       turn = -TURN_QUARTER;
                4:       turn = TURN_THIRD;
                5:       turn = TURN_NEG_TRD;
                6:       turn = TURN_MAX;
                default: turn = TURN_NEG_ONE;
            endcase
        end
        send_motion(dx, dy, turn);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: offset extremes, then heading corners
        send_motion('0, '0, TURN_NONE);
        send_motion(D_MAX, '0, TURN_NONE);
        send_motion(D_MIN, '0, TURN_NONE);
        send_motion('0, D_MAX, TURN_NONE);
        send_motion('0, D_MIN, TURN_NONE);
        send_motion(D_MAX, D_MAX, TURN_QUARTER);
        send_motion(D_MAX, D_MIN, TURN_NONE);
        // land exactly on -pi, then move while there
        send_motion(D_MIN, D_MAX, TURN_QUARTER);
        send_motion(24'd4096, 24'd4096, TURN_NONE);
        send_motion('0, '0, TURN_MAX);
        // step across the -2pi/3 flip point both ways
        send_motion('0, '0, TURN_NEG_TRD);
        send_motion(24'd1, '0, 16'h0001);
        send_motion('0, 24'd1, TURN_NEG_ONE);
        // wrap the heading through +-pi in both directions
        send_motion(D_MAX, D_MAX, TURN_HALF);
        send_motion(D_MIN, D_MIN, TURN_MAX);
        send_motion(24'd1, D_NEG_ONE, 16'h5557);
        send_motion(D_NEG_ONE, 24'd1, TURN_HALF);
        send_motion(24'd1, 24'd1, TURN_NEG_ONE);
        send_motion(D_MAX, D_MIN, TURN_THIRD);
        send_motion(24'h555555, 24'hAAAAAA, 16'h5A5A);
        send_motion(24'hAAAAAA, 24'h555555, 16'hA5A5);
        drain_poses();

        repeat (100) send_random_motion();

        // Hold heading at +pi/2 and drive hard: x runs to its low limit, y to its high
        send_motion(D_MAX, D_MAX, TURN_QUARTER - sent_heading);
        repeat (299) begin
            send_motion(D_MAX - 24'($urandom_range(0, 255)),
                        D_MAX - 24'($urandom_range(0, 255)), TURN_NONE);
        end
        drain_poses();

        // Random tail with a stretch free of idling on both sides
        for (int n = 0; n < 150; n++) begin
            idle_pct = (n >= 40 && n < 110) ? 0 : IDLE_PCT;
            send_random_motion();
        end

        drain_poses();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d motion items and checked %0d poses: offset and turn extremes,",
                 sent_count, checked);
        $display("heading wraps, the -pi and -2pi/3 quaternion corners, and position saturation.");
        if (errors == 0) begin
            $display("PASS planar_pose_integrator");
        end else begin
            $display("FAIL planar_pose_integrator");
        end
        $finish;
    end

endmodule
